[design/wrp_pkg.sv]
// wrp_pkg: request and result types, tags and fixed header offsets for the
// riff/wave header parser. no dependencies.
package wrp_pkg;

    // result status codes
    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_NO_RIFF   = 3'd1,
        STATUS_SIZE_LOW  = 3'd2,
        STATUS_NOT_WAVE  = 3'd3,
        STATUS_NO_FMT    = 3'd4,
        STATUS_NO_DATA   = 3'd5,
        STATUS_MALFORMED = 3'd6
    } status_t;

    // one byte of the file
    typedef struct packed {
        logic [7:0] file_byte;
        logic       last_byte;
    } in_item_t;

    // one result per file
    typedef struct packed {
        status_t     status;
        logic [15:0] format_code;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] frame_size;
        logic [15:0] bit_depth;
        logic [15:0] extra_size;
        logic [30:0] data_offset;
        logic [30:0] data_size;
    } out_item_t;

    // chunk and form tags, big-endian as they appear in the byte stream
    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    // fixed offsets of the file header
    localparam logic [31:0] POS_RIFF_TAG  = 32'd3;
    localparam logic [31:0] POS_RIFF_SIZE = 32'd7;
    localparam logic [31:0] POS_WAVE_TAG  = 32'd11;
    localparam logic [31:0] CHAIN_START   = 32'd12;
    localparam logic [31:0] MIN_RIFF_SIZE = 32'd16;

    // chunk header geometry
    localparam logic [32:0] CHUNK_HDR_LAST  = 33'd7;
    localparam logic [30:0] CHUNK_HDR_BYTES = 31'd8;
    localparam logic [32:0] CHUNK_PAD_STEP  = 33'd9;

    // captured fmt bytes
    localparam int FMT_BYTES = 18;
    localparam logic [4:0] FMT_COUNT_END = 5'd18;

    localparam logic [31:0] POS_MAX = 32'hFFFFFFFF;

endpackage

[design/wrp_input_reg.sv]
// wrp_input_reg: input register holding one byte request ahead of the parser.
// depends on wrp_pkg for the request type.
module wrp_input_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  wrp_pkg::in_item_t req_item,
    input  logic              drain,
    output logic              held_valid,
    output wrp_pkg::in_item_t held_item
);

    logic              valid_reg;
    logic              valid_next;
    wrp_pkg::in_item_t item_reg;

    // room whenever empty or the held byte moves on this cycle
    assign req_ready = !valid_reg || drain;

    always_comb
    begin
        valid_next = valid_reg;
        if (req_valid && req_ready)
        begin
            valid_next = 1'b1;
        end
        else if (drain)
        begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

[design/wrp_parse_core.sv]
// wrp_parse_core: per-byte header checks, chunk chain walk and fmt/data capture.
// depends on wrp_pkg for types, tags and offsets.
module wrp_parse_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  wrp_pkg::in_item_t  item,
    output wrp_pkg::out_item_t result
);

    logic [31:0]      pos_reg, pos_next;
    logic [31:0]      riff_size_reg, riff_size_next;
    logic [31:0]      chunk_start_reg, chunk_start_next;
    logic [55:0]      shift_reg, shift_next;
    logic             fmt_found_reg, fmt_found_next;
    logic             data_found_reg, data_found_next;
    logic             walk_over_reg, walk_over_next;
    wrp_pkg::status_t verdict_reg, verdict_next;
    logic [30:0]      data_off_reg, data_off_next;
    logic [30:0]      data_size_reg, data_size_next;
    logic [4:0]       cap_count_reg, cap_count_next;
    logic [7:0]       cap_reg [wrp_pkg::FMT_BYTES];
    logic [7:0]       cap_view [wrp_pkg::FMT_BYTES];

    logic [7:0]       b;
    logic [63:0]      win;
    logic [31:0]      low;
    logic [31:0]      chunk_id;
    logic [31:0]      size;
    logic [32:0]      hdr_end;
    logic [32:0]      step_sum;
    logic             cap_active;
    logic             walk_en;
    wrp_pkg::status_t status;

    // eight-byte window ending at the current byte
    assign b        = item.file_byte;
    assign win      = {shift_reg, b};
    assign low      = win[31:0];
    assign chunk_id = win[63:32];
    assign size     = {low[7:0], low[15:8], low[23:16], low[31:24]};

    // chunk header end and padded step to the next chunk
    assign hdr_end  = {1'b0, chunk_start_reg} + wrp_pkg::CHUNK_HDR_LAST;
    assign step_sum = {1'b0, chunk_start_reg}
                    + (({1'b0, size} + wrp_pkg::CHUNK_PAD_STEP) & ~33'd1);

    assign cap_active = fmt_found_reg && (cap_count_reg != wrp_pkg::FMT_COUNT_END);

    // capture bytes as seen with the current byte merged in
    always_comb
    begin
        for (int i = 0; i < wrp_pkg::FMT_BYTES; i++)
        begin
            cap_view[i] = cap_reg[i];
            if (cap_active && cap_count_reg == 5'(i))
            begin
                cap_view[i] = b;
            end
        end
    end

    // header checks and chunk walk
    always_comb
    begin
        verdict_next     = verdict_reg;
        riff_size_next   = riff_size_reg;
        chunk_start_next = chunk_start_reg;
        fmt_found_next   = fmt_found_reg;
        data_found_next  = data_found_reg;
        walk_over_next   = walk_over_reg;
        data_off_next    = data_off_reg;
        data_size_next   = data_size_reg;
        cap_count_next   = cap_active ? cap_count_reg + 5'd1 : cap_count_reg;

        if (verdict_reg == wrp_pkg::STATUS_OK)
        begin
            if (pos_reg == wrp_pkg::POS_RIFF_TAG && low != wrp_pkg::TAG_RIFF)
            begin
                verdict_next = wrp_pkg::STATUS_NO_RIFF;
            end
            if (pos_reg == wrp_pkg::POS_RIFF_SIZE)
            begin
                riff_size_next = size;
                if (size[31] || size <= wrp_pkg::MIN_RIFF_SIZE)
                begin
                    verdict_next = wrp_pkg::STATUS_SIZE_LOW;
                end
            end
            if (pos_reg == wrp_pkg::POS_WAVE_TAG && low != wrp_pkg::TAG_WAVE)
            begin
                verdict_next = wrp_pkg::STATUS_NOT_WAVE;
            end
        end

        walk_en = (verdict_next == wrp_pkg::STATUS_OK) && (pos_reg >= wrp_pkg::CHAIN_START)
                && !walk_over_reg;
        if (walk_en)
        begin
            if (chunk_start_reg >= riff_size_reg)
            begin
                walk_over_next = 1'b1;
            end
            else if ({1'b0, pos_reg} == hdr_end)
            begin
                if (size[31])
                begin
                    verdict_next   = wrp_pkg::STATUS_MALFORMED;
                    walk_over_next = 1'b1;
                end
                else
                begin
                    if (chunk_id == wrp_pkg::TAG_FMT && !fmt_found_reg)
                    begin
                        fmt_found_next = 1'b1;
                    end
                    if (chunk_id == wrp_pkg::TAG_DATA && !data_found_reg)
                    begin
                        data_found_next = 1'b1;
                        data_off_next   = chunk_start_reg[30:0] + wrp_pkg::CHUNK_HDR_BYTES;
                        data_size_next  = size[30:0];
                    end
                    if (fmt_found_next && data_found_next)
                    begin
                        walk_over_next = 1'b1;
                    end
                    else
                    begin
                        chunk_start_next = step_sum[32] ? wrp_pkg::POS_MAX : step_sum[31:0];
                    end
                end
            end
        end

        pos_next   = (pos_reg == wrp_pkg::POS_MAX) ? pos_reg : pos_reg + 32'd1;
        shift_next = win[55:0];
    end

    // final status for a last byte
    always_comb
    begin
        if (verdict_next != wrp_pkg::STATUS_OK)
        begin
            status = verdict_next;
        end
        else if (pos_reg < wrp_pkg::POS_RIFF_TAG)
        begin
            status = wrp_pkg::STATUS_NO_RIFF;
        end
        else if (pos_reg < wrp_pkg::POS_RIFF_SIZE)
        begin
            status = wrp_pkg::STATUS_SIZE_LOW;
        end
        else if (pos_reg < wrp_pkg::POS_WAVE_TAG)
        begin
            status = wrp_pkg::STATUS_NOT_WAVE;
        end
        else if (!fmt_found_next)
        begin
            status = wrp_pkg::STATUS_NO_FMT;
        end
        else if (!data_found_next)
        begin
            status = wrp_pkg::STATUS_NO_DATA;
        end
        else
        begin
            status = wrp_pkg::STATUS_OK;
        end
    end

    // result fields, fmt bytes little-endian
    always_comb
    begin
        result.status        = status;
        result.format_code   = {cap_view[1], cap_view[0]};
        result.channel_count = {cap_view[3], cap_view[2]};
        result.sample_rate   = {cap_view[7], cap_view[6], cap_view[5], cap_view[4]};
        result.byte_rate     = {cap_view[11], cap_view[10], cap_view[9], cap_view[8]};
        result.frame_size    = {cap_view[13], cap_view[12]};
        result.bit_depth     = {cap_view[15], cap_view[14]};
        result.extra_size    = {cap_view[17], cap_view[16]};
        result.data_offset   = data_off_next;
        result.data_size     = data_size_next;
    end

    // parser state, back to reset values after a last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            riff_size_reg   <= '0;
            chunk_start_reg <= wrp_pkg::CHAIN_START;
            shift_reg       <= '0;
            fmt_found_reg   <= 1'b0;
            data_found_reg  <= 1'b0;
            walk_over_reg   <= 1'b0;
            verdict_reg     <= wrp_pkg::STATUS_OK;
            data_off_reg    <= '0;
            data_size_reg   <= '0;
            cap_count_reg   <= '0;
            for (int i = 0; i < wrp_pkg::FMT_BYTES; i++)
            begin
                cap_reg[i] <= '0;
            end
        end
        else if (step_en)
        begin
            if (item.last_byte)
            begin
                pos_reg         <= '0;
                riff_size_reg   <= '0;
                chunk_start_reg <= wrp_pkg::CHAIN_START;
                shift_reg       <= '0;
                fmt_found_reg   <= 1'b0;
                data_found_reg  <= 1'b0;
                walk_over_reg   <= 1'b0;
                verdict_reg     <= wrp_pkg::STATUS_OK;
                data_off_reg    <= '0;
                data_size_reg   <= '0;
                cap_count_reg   <= '0;
                for (int i = 0; i < wrp_pkg::FMT_BYTES; i++)
                begin
                    cap_reg[i] <= '0;
                end
            end
            else
            begin
                pos_reg         <= pos_next;
                riff_size_reg   <= riff_size_next;
                chunk_start_reg <= chunk_start_next;
                shift_reg       <= shift_next;
                fmt_found_reg   <= fmt_found_next;
                data_found_reg  <= data_found_next;
                walk_over_reg   <= walk_over_next;
                verdict_reg     <= verdict_next;
                data_off_reg    <= data_off_next;
                data_size_reg   <= data_size_next;
                cap_count_reg   <= cap_count_next;
                for (int i = 0; i < wrp_pkg::FMT_BYTES; i++)
                begin
                    cap_reg[i] <= cap_view[i];
                end
            end
        end
    end

endmodule

[design/wav_riff_header_parser_unit.sv]
// wav_riff_header_parser_unit: top level, input register, parser and result register.
// depends on wrp_pkg, wrp_input_reg and wrp_parse_core.
//
// usage:
//   byte channel (byte_valid/byte_ready/byte_data) takes a wav file one byte a
//   request, in file order from offset zero; last_byte marks the final byte.
//   result channel (result_valid/result_ready/result_data) gives one status
//   request per file, with the fmt fields and data chunk location.
//   throughput: one byte per cycle, set by the single parse step between the
//   input register and the result register, unless a waiting result holds a last byte.
//   a result is registered when its last byte moves on from the input register
//   (the byte sits in the input register while the parse step works on it).
//   after a last byte the parser is back in its reset state, so the next
//   file's first byte may follow in the very next cycle.
//   reset: all parser state clears, both channels go empty.
//   receiver stall: bytes keep flowing while a result waits; only a further
//   last byte is held in the input register until the waiting result is taken.
module wav_riff_header_parser_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  wrp_pkg::in_item_t  byte_data,
    output logic               result_valid,
    input  logic               result_ready,
    output wrp_pkg::out_item_t result_data
);

    logic               held_valid;
    wrp_pkg::in_item_t  held_item;
    logic               advance;
    logic               slot_free;
    wrp_pkg::out_item_t core_result;
    logic               result_valid_reg, result_valid_next;
    wrp_pkg::out_item_t result_reg;

    // a byte moves on unless it would produce a result with no room for it
    assign slot_free = !result_valid_reg || result_ready;
    assign advance   = held_valid && (!held_item.last_byte || slot_free);

    wrp_input_reg u_input_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (byte_valid),
        .req_ready  (byte_ready),
        .req_item   (byte_data),
        .drain      (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    wrp_parse_core u_parse_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (held_item),
        .result  (core_result)
    );

    // result register valid
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (advance && held_item.last_byte)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && held_item.last_byte)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule

[tb/wav_riff_header_parser_unit_tb.sv]
// wav_riff_header_parser_unit_tb: self-checking bench for the riff/wave header parser.
// depends on wrp_pkg and wav_riff_header_parser_unit; byte-level predictor, queued
// file generator, clocked driver and monitor, watchdog.
module wav_riff_header_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASE_BYTES     = 110;
    localparam int PHASE_FILES     = 2;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_REPORTS     = 100;
    localparam int FILL_RANDOM     = -1;
    localparam logic [31:0] TAG_JUNK = 32'h4C495354;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // dut ports
    logic               byte_valid = 1'b0;
    logic               byte_ready;
    wrp_pkg::in_item_t  byte_data = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    wrp_pkg::out_item_t result_data;

    wav_riff_header_parser_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    // bench bookkeeping
    wrp_pkg::in_item_t  pending_bytes[$];
    wrp_pkg::out_item_t expected_headers[$];
    logic [7:0] file_buf[$];
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         byte_fired = 1'b0;
    int         stall_cycles = 0;
    int         mismatch_count = 0;
    int         bytes_queued = 0;
    int         files_queued = 0;
    int         results_checked = 0;
    int         status_seen [0:7];

    // predictor state, one file at a time
    logic [31:0] cur_pos;
    logic [31:0] form_size;
    logic [31:0] chunk_start;
    logic [63:0] byte_window;
    logic [7:0]  fmt_bytes [0:wrp_pkg::FMT_BYTES-1];
    logic [31:0] fmt_origin;
    logic [30:0] data_off;
    logic [30:0] data_len;
    bit          fmt_seen;
    bit          data_seen;
    bit          walk_done;
    wrp_pkg::status_t pending_status;

    function automatic logic [31:0] le32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    task automatic reset_parser_model();
        cur_pos        = '0;
        form_size      = '0;
        chunk_start    = wrp_pkg::CHAIN_START;
        byte_window    = '0;
        fmt_origin     = '0;
        data_off       = '0;
        data_len       = '0;
        fmt_seen       = 1'b0;
        data_seen      = 1'b0;
        walk_done      = 1'b0;
        pending_status = wrp_pkg::STATUS_OK;
        for (int i = 0; i < wrp_pkg::FMT_BYTES; i++)
            fmt_bytes[i] = '0;
    endtask

    // chunk chain walk, acts on the last byte of each chunk header
    task automatic walk_step(input logic [31:0] p);
        logic [31:0] id;
        logic [31:0] sz;
        logic [32:0] step;
        if (chunk_start >= form_size)
        begin
            walk_done = 1'b1;
            return;
        end
        if (p < chunk_start || p - chunk_start != 32'd7)
            return;
        id = byte_window[63:32];
        sz = le32(byte_window[31:0]);
        if (sz[31])
        begin
            pending_status = wrp_pkg::STATUS_MALFORMED;
            walk_done = 1'b1;
            return;
        end
        if (id == wrp_pkg::TAG_FMT && !fmt_seen)
        begin
            fmt_seen   = 1'b1;
            fmt_origin = chunk_start + 32'd8;
        end
        if (id == wrp_pkg::TAG_DATA && !data_seen)
        begin
            data_seen = 1'b1;
            data_off  = chunk_start[30:0] + 31'd8;
            data_len  = sz[30:0];
        end
        if (fmt_seen && data_seen)
        begin
            walk_done = 1'b1;
            return;
        end
        step = {1'b0, chunk_start} + (({1'b0, sz} + 33'd9) & ~33'd1);
        chunk_start = step[32] ? wrp_pkg::POS_MAX : step[31:0];
    endtask

    // one accepted byte; a last byte queues the header it closes
    task automatic parse_header_byte(input wrp_pkg::in_item_t item);
        logic [31:0] p;
        logic [31:0] low;
        wrp_pkg::out_item_t res;
        p = cur_pos;
        byte_window = {byte_window[55:0], item.file_byte};
        low = byte_window[31:0];
        if (pending_status == wrp_pkg::STATUS_OK)
        begin
            if (p == wrp_pkg::POS_RIFF_TAG && low != wrp_pkg::TAG_RIFF)
                pending_status = wrp_pkg::STATUS_NO_RIFF;
            if (p == wrp_pkg::POS_RIFF_SIZE)
            begin
                form_size = le32(low);
                if (form_size[31] || form_size <= wrp_pkg::MIN_RIFF_SIZE)
                    pending_status = wrp_pkg::STATUS_SIZE_LOW;
            end
            if (p == wrp_pkg::POS_WAVE_TAG && low != wrp_pkg::TAG_WAVE)
                pending_status = wrp_pkg::STATUS_NOT_WAVE;
        end
        if (fmt_seen && p >= fmt_origin && p - fmt_origin < wrp_pkg::FMT_BYTES)
            fmt_bytes[p - fmt_origin] = item.file_byte;
        if (pending_status == wrp_pkg::STATUS_OK && p >= wrp_pkg::CHAIN_START && !walk_done)
            walk_step(p);
        if (cur_pos != wrp_pkg::POS_MAX)
            cur_pos = cur_pos + 32'd1;
        if (item.last_byte)
        begin
            if (pending_status != wrp_pkg::STATUS_OK)
                res.status = pending_status;
            else if (p < wrp_pkg::POS_RIFF_TAG)
                res.status = wrp_pkg::STATUS_NO_RIFF;
            else if (p < wrp_pkg::POS_RIFF_SIZE)
                res.status = wrp_pkg::STATUS_SIZE_LOW;
            else if (p < wrp_pkg::POS_WAVE_TAG)
                res.status = wrp_pkg::STATUS_NOT_WAVE;
            else if (!fmt_seen)
                res.status = wrp_pkg::STATUS_NO_FMT;
            else if (!data_seen)
                res.status = wrp_pkg::STATUS_NO_DATA;
            else
                res.status = wrp_pkg::STATUS_OK;
            res.format_code   = {fmt_bytes[1], fmt_bytes[0]};
            res.channel_count = {fmt_bytes[3], fmt_bytes[2]};
            res.sample_rate   = {fmt_bytes[7], fmt_bytes[6], fmt_bytes[5], fmt_bytes[4]};
            res.byte_rate     = {fmt_bytes[11], fmt_bytes[10], fmt_bytes[9], fmt_bytes[8]};
            res.frame_size    = {fmt_bytes[13], fmt_bytes[12]};
            res.bit_depth     = {fmt_bytes[15], fmt_bytes[14]};
            res.extra_size    = {fmt_bytes[17], fmt_bytes[16]};
            res.data_offset   = data_off;
            res.data_size     = data_len;
            expected_headers.push_back(res);
            reset_parser_model();
        end
    endtask

    // file assembly helpers
    function automatic logic [7:0] pay(input int fill);
        return (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
    endfunction

    task automatic put8(input logic [7:0] b);
        file_buf.push_back(b);
    endtask

    task automatic put32le(input logic [31:0] v);
        put8(v[7:0]);
        put8(v[15:8]);
        put8(v[23:16]);
        put8(v[31:24]);
    endtask

    task automatic put_tag(input logic [31:0] t);
        put8(t[31:24]);
        put8(t[23:16]);
        put8(t[15:8]);
        put8(t[7:0]);
    endtask

    task automatic patch_riff(input logic [31:0] v);
        file_buf[4] = v[7:0];
        file_buf[5] = v[15:8];
        file_buf[6] = v[23:16];
        file_buf[7] = v[31:24];
    endtask

    // payload only for small sizes, large sizes end the file at the header
    task automatic add_chunk(input logic [31:0] tag, input logic [31:0] size, input int fill);
        put_tag(tag);
        put32le(size);
        if (size < 64)
        begin
            for (int i = 0; i < int'(size); i++)
                put8(pay(fill));
            if (size[0])
                put8(pay(fill));
        end
    endtask

    task automatic build_chain(input bit with_fmt, input bit with_data, input bit fmt_first,
                               input int fmt_size, input logic [31:0] data_size,
                               input int junk_count, input int junk_size, input int fill);
        file_buf.delete();
        put_tag(wrp_pkg::TAG_RIFF);
        put32le('0);
        put_tag(wrp_pkg::TAG_WAVE);
        repeat (junk_count)
            add_chunk(TAG_JUNK, junk_size, fill);
        if (with_fmt && fmt_first)
            add_chunk(wrp_pkg::TAG_FMT, fmt_size, fill);
        if (with_data)
            add_chunk(wrp_pkg::TAG_DATA, data_size, fill);
        if (with_fmt && !fmt_first)
            add_chunk(wrp_pkg::TAG_FMT, fmt_size, fill);
        patch_riff(file_buf.size() - ((with_data && data_size >= 64) ? 0 : 8));
    endtask

    // move the assembled file to the request queue, ending it after len bytes
    task automatic commit_file(input int len);
        int n;
        wrp_pkg::in_item_t item;
        n = (len <= 0 || len > file_buf.size()) ? file_buf.size() : len;
        for (int i = 0; i < n; i++)
        begin
            item.file_byte = file_buf[i];
            item.last_byte = (i == n - 1);
            pending_bytes.push_back(item);
        end
        bytes_queued += n;
        files_queued++;
        file_buf.delete();
    endtask

    // directed files: short headers, bad tags, size limits, chunk order cases
    task automatic queue_directed_files();
        file_buf.delete();
        put8(8'h52);
        commit_file(0);
        build_chain(1, 1, 1, 16, 2, 0, 0, 8'hFF);
        commit_file(3);
        build_chain(1, 1, 1, 16, 2, 0, 0, 8'hFF);
        file_buf[3] = 8'h58;
        commit_file(0);
        build_chain(1, 1, 1, 16, 2, 0, 0, 8'hFF);
        commit_file(6);
        build_chain(1, 1, 1, 16, 2, 0, 0, 8'h00);
        patch_riff(wrp_pkg::MIN_RIFF_SIZE);
        commit_file(0);
        build_chain(1, 1, 1, 16, 2, 0, 0, 8'h00);
        patch_riff(wrp_pkg::MIN_RIFF_SIZE + 32'd1);
        commit_file(0);
        build_chain(1, 1, 1, 16, 2, 0, 0, 8'h00);
        patch_riff(32'h80000024);
        commit_file(0);
        build_chain(1, 1, 1, 16, 2, 0, 0, 8'h00);
        commit_file(11);
        build_chain(1, 1, 1, 16, 2, 0, 0, 8'h00);
        file_buf[10] = 8'h46;
        commit_file(0);
        build_chain(1, 1, 1, 16, 2, 0, 0, 8'hFF);
        commit_file(0);
        build_chain(1, 1, 1, 18, 2, 0, 0, 8'h00);
        commit_file(0);
        build_chain(1, 1, 1, 16, 32'h80000000, 0, 0, FILL_RANDOM);
        commit_file(0);
        build_chain(1, 1, 1, 16, 32'h7FFFFFFF, 0, 0, 8'hFF);
        commit_file(0);
        build_chain(0, 1, 1, 16, 4, 1, 3, FILL_RANDOM);
        commit_file(0);
        build_chain(1, 0, 1, 16, 4, 0, 0, FILL_RANDOM);
        commit_file(0);
        build_chain(1, 1, 0, 20, 3, 2, 5, FILL_RANDOM);
        commit_file(0);
        build_chain(1, 1, 1, 16, 2, 0, 0, FILL_RANDOM);
        commit_file(41);
        build_chain(1, 1, 1, 0, 6, 0, 0, FILL_RANDOM);
        commit_file(0);
    endtask

    // random file: mostly well-formed chains, some broken or pure noise
    task automatic queue_random_file();
        int kind;
        int fmt_size;
        int roll;
        int cut;
        bit fmt_first;
        bit big_data;
        logic [31:0] data_size;
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            file_buf.delete();
            if ($urandom_range(1))
                put_tag(wrp_pkg::TAG_RIFF);
            repeat ($urandom_range(1, 24))
                put8(pay(FILL_RANDOM));
            commit_file(0);
            return;
        end
        big_data  = ($urandom_range(99) < 15);
        fmt_first = big_data || ($urandom_range(99) < 80);
        fmt_size  = ($urandom_range(99) < 60) ? 16 : $urandom_range(0, 26);
        data_size = big_data ? $urandom : 32'($urandom_range(0, 14));
        build_chain($urandom_range(99) < 92, $urandom_range(99) < 92, fmt_first, fmt_size,
                    data_size, $urandom_range(0, 2), $urandom_range(0, 9), FILL_RANDOM);
        roll = $urandom_range(99);
        if (roll < 8)
            patch_riff($urandom_range(17, file_buf.size()));
        else if (roll < 12)
            patch_riff($urandom_range(0, 16));
        else if (roll < 15)
            patch_riff($urandom | 32'h80000000);
        if ($urandom_range(99) < 10)
            file_buf[$urandom_range(0, file_buf.size() - 1)] = pay(FILL_RANDOM);
        cut = ($urandom_range(99) < 15) ? $urandom_range(1, file_buf.size()) : 0;
        commit_file(cut);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch in %s: got %0h, expected %0h", what, got, want);
        mismatch_count++;
    endtask

    // byte driver and result back-pressure, both on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!byte_valid || byte_fired)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    byte_data  <= pending_bytes.pop_front();
                    byte_valid <= 1'b1;
                end
                else
                    byte_valid <= 1'b0;
            end
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: feed accepted bytes to the predictor, check accepted results
    always @(posedge clk)
    begin : monitor
        wrp_pkg::out_item_t want;
        bit result_fired;
        byte_fired   = rst_n && byte_valid && byte_ready;
        result_fired = rst_n && result_valid && result_ready;
        if (byte_fired)
            parse_header_byte(byte_data);
        if (result_fired)
        begin
            results_checked++;
            status_seen[int'(result_data.status)]++;
            if (expected_headers.size() == 0)
                report_mismatch("unexpected result status", result_data.status, '0);
            else
            begin
                want = expected_headers.pop_front();
                if (result_data.status != want.status)
                    report_mismatch("status", result_data.status, want.status);
                if (result_data.format_code != want.format_code)
                    report_mismatch("format_code", result_data.format_code, want.format_code);
                if (result_data.channel_count != want.channel_count)
                    report_mismatch("channel_count", result_data.channel_count,
                                    want.channel_count);
                if (result_data.sample_rate != want.sample_rate)
                    report_mismatch("sample_rate", result_data.sample_rate, want.sample_rate);
                if (result_data.byte_rate != want.byte_rate)
                    report_mismatch("byte_rate", result_data.byte_rate, want.byte_rate);
                if (result_data.frame_size != want.frame_size)
                    report_mismatch("frame_size", result_data.frame_size, want.frame_size);
                if (result_data.bit_depth != want.bit_depth)
                    report_mismatch("bit_depth", result_data.bit_depth, want.bit_depth);
                if (result_data.extra_size != want.extra_size)
                    report_mismatch("extra_size", result_data.extra_size, want.extra_size);
                if (result_data.data_offset != want.data_offset)
                    report_mismatch("data_offset", result_data.data_offset, want.data_offset);
                if (result_data.data_size != want.data_size)
                    report_mismatch("data_size", result_data.data_size, want.data_size);
            end
        end
        if (byte_fired || result_fired)
            stall_cycles = 0;
        else if (rst_n)
            stall_cycles++;
    end

    // watchdog on cycles with no request accepted
    initial
    begin : watchdog
        wait (rst_n === 1'b1);
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("no request accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // stimulus in three idling phases
    initial
    begin : stimulus
        int start_bytes;
        int start_files;
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;
        reset_parser_model();
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 55 : 0;
            recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 8 : 0;
            if (phase == 0)
                queue_directed_files();
            start_bytes = bytes_queued;
            start_files = files_queued;
            while (bytes_queued - start_bytes < PHASE_BYTES ||
                   files_queued - start_files < PHASE_FILES)
                queue_random_file();
            while (pending_bytes.size() != 0 || byte_valid || expected_headers.size() != 0)
                @(posedge clk);
        end
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        $display("covered %0d bytes in %0d files, %0d results checked",
                 bytes_queued, files_queued, results_checked);
        $display("by status: ok %0d, no riff %0d, size low %0d, not wave %0d, %s%0d, %s%0d, %s%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 "no fmt ", status_seen[4], "no data ", status_seen[5],
                 "malformed ", status_seen[6]);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
design/wrp_pkg.sv
design/wrp_input_reg.sv
design/wrp_parse_core.sv
design/wav_riff_header_parser_unit.sv
tb/wav_riff_header_parser_unit_tb.sv
